// ===== rtl/pgt_pkg.sv =====
// ----------------------------------------------------------------------------
// pgt_pkg - shared constants, types and table builders for the gamma block
//
// Holds the pixel width, the log2 table (built at elaboration) and the
// sixteen square-root constants that drive the exp2 multiply chain.
// ----------------------------------------------------------------------------
package pgt_pkg;

	// Pixel width and full-scale code
	localparam int PIXEL_BITS = 8;
	localparam int PIX_MAX    = (1 << PIXEL_BITS) - 1;

	// Fraction bits of the exact log/exp arithmetic
	localparam int FB = 30;

	// |log2(x/M)| in Q16 stays below PIXEL_BITS * 2^16
	localparam int LQ_BITS = $clog2(PIXEL_BITS) + 16;

	// Gamma register
	localparam int GAMMA_BITS = 16;
	localparam logic [GAMMA_BITS-1:0] GAMMA_RESET = 16'd4096;

	// Exponent magnitude in Q16, limited to 16.0 once the large case is removed
	localparam int EXP_N_BITS = 21;
	localparam int EXP_STEPS  = 16;

	// Mantissa of 2^x in Q30, always below 2.0
	localparam int MANT_BITS = FB + 1;
	localparam logic [MANT_BITS-1:0] MANT_ONE = MANT_BITS'(1) << FB;

	// Result override code carried down the pipeline
	typedef enum logic [1:0] {
		SP_PASS,
		SP_ZERO,
		SP_FULL
	} spec_t;

	typedef logic [LQ_BITS-1:0]   lq_rom_t   [0:PIX_MAX];
	typedef logic [MANT_BITS-1:0] exp_root_t [0:EXP_STEPS-1];

	// log2(v) in Q30 by repeated squaring, for 1 <= v < 2^30
	function automatic logic [63:0] log2_q30(input logic [63:0] v);
		logic [63:0] m;
		logic [63:0] r;
		int          e;
		e = 0;
		for (int b = 1; b < 63; b++) begin
			if ((v >> b) != 64'd0)
				e = b;
		end
		m = v << (FB - e);
		r = 64'(e) << FB;
		for (int k = FB - 1; k >= 0; k--) begin
			m = (m * m) >> FB;
			if (m >= (64'd2 << FB)) begin
				m = m >> 1;
				r[k] = 1'b1;
			end
		end
		return r;
	endfunction

	// Integer square root by the digit-pair method
	function automatic logic [63:0] isqrt64(input logic [63:0] xin);
		logic [63:0] x;
		logic [63:0] res;
		logic [63:0] bitv;
		x    = xin;
		res  = 64'd0;
		bitv = 64'd1 << 62;
		for (int t = 0; t < 32; t++) begin
			if (bitv > x)
				bitv = bitv >> 2;
		end
		for (int t = 0; t < 32; t++) begin
			if (bitv != 64'd0) begin
				if (x >= res + bitv) begin
					x   = x - (res + bitv);
					res = (res >> 1) + bitv;
				end else begin
					res = res >> 1;
				end
				bitv = bitv >> 2;
			end
		end
		return res;
	endfunction

	// |log2(x/M)| in Q16, rounded to nearest; zero for black and full scale
	function automatic lq_rom_t build_lq_rom();
		lq_rom_t     rom;
		logic [63:0] lm;
		logic [63:0] d;
		logic [63:0] lq;
		lm = log2_q30(64'(PIX_MAX));
		for (int x = 0; x <= PIX_MAX; x++) begin
			if (x == 0 || x == PIX_MAX) begin
				rom[x] = '0;
			end else begin
				d      = lm - log2_q30(64'(x));
				lq     = (d + (64'd1 << (FB - 17))) >> (FB - 16);
				rom[x] = LQ_BITS'(lq);
			end
		end
		return rom;
	endfunction

	// 2^(2^-k) in Q30 for k = 1..16, each from the previous by a square root
	function automatic exp_root_t build_exp_roots();
		exp_root_t   roots;
		logic [63:0] c;
		c = 64'd2 << FB;
		for (int k = 0; k < EXP_STEPS; k++) begin
			c        = isqrt64(c << FB);
			roots[k] = MANT_BITS'(c);
		end
		return roots;
	endfunction

	localparam lq_rom_t   LQ_ROM    = build_lq_rom();
	localparam exp_root_t EXP_ROOTS = build_exp_roots();

endpackage

// ===== rtl/pixel_gamma_transform.sv =====
// ----------------------------------------------------------------------------
// pixel_gamma_transform - fixed-point gamma correction of grey pixels
//
// Maps each pixel x to floor(M * (x/M)^gamma) through a log2 table, a
// gamma multiply and a sixteen-step exp2 multiply chain.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: pixel_in with in_valid; the block drives in_stall.
//   Output channel: pixel_out with out_valid; the receiver drives out_stall.
//   An item moves on an edge where valid is high and stall is low.
//   gamma_q4_12 (Q4.12, 4096 = 1.0) is written on any edge with gamma_we
//   high; write it only while no item is inside the pipeline.
//   Depth: 21 register stages. Throughput: one item per cycle when nothing
//   stalls. The depth comes from the exp2 chain, one 31x31 multiply per
//   stage over sixteen stages, after the table, gamma multiply and fraction
//   stages, and before the rounding shift and the final scale by M.
//   Stall: each stage holds only while it is full and the stage after it
//   holds, so bubbles close up and in_stall rises only when every stage is
//   full and out_stall is high.
//   Reset empties the pipeline and sets gamma to 1.0.
// ----------------------------------------------------------------------------
module pixel_gamma_transform (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             gamma_we,
	input  logic [pgt_pkg::GAMMA_BITS-1:0]   gamma_q4_12,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [pgt_pkg::PIXEL_BITS-1:0]   pixel_in,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [pgt_pkg::PIXEL_BITS-1:0]   pixel_out
);

	localparam int NUM_STG  = 5 + pgt_pkg::EXP_STEPS;
	localparam int EXP_BASE = 3;
	localparam int LAST_E   = pgt_pkg::EXP_STEPS - 1;
	localparam int PB       = pgt_pkg::PIXEL_BITS;
	localparam int MB       = pgt_pkg::MANT_BITS;
	localparam int NB       = pgt_pkg::EXP_N_BITS;
	localparam int LB       = pgt_pkg::LQ_BITS;
	localparam int GB       = pgt_pkg::GAMMA_BITS;
	localparam int PROD_B   = LB + GB + 1;
	localparam int NFULL_B  = PROD_B - 12;
	localparam logic [NFULL_B-1:0] EXP_LIMIT = NFULL_B'(16 << 16);
	localparam logic [PB-1:0]      PIX_FULL  = PB'(pgt_pkg::PIX_MAX);

	// Gamma register
	logic [GB-1:0] gamma_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q <= pgt_pkg::GAMMA_RESET;
		end else if (gamma_we) begin
			gamma_q <= gamma_q4_12;
		end
	end

	// Stage valid bits and advance chain: a stage loads when empty or when
	// the stage after it moves
	logic [NUM_STG-1:0] vld_q;
	logic [NUM_STG:0]   adv;

	assign adv[NUM_STG] = !out_stall;

	for (genvar i = 0; i < NUM_STG; i++) begin : g_adv
		assign adv[i] = !vld_q[i] || adv[i+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0])
				vld_q[0] <= in_valid;
			for (int i = 1; i < NUM_STG; i++) begin
				if (adv[i])
					vld_q[i] <= vld_q[i-1];
			end
		end
	end

	assign in_stall  = !adv[0];
	assign out_valid = vld_q[NUM_STG-1];

	// Stage 1: table lookup and black / full-scale detection
	logic [LB-1:0]       lq_s1;
	pgt_pkg::spec_t      spec_s1;
	pgt_pkg::spec_t      spec_in;

	always_comb begin
		if (pixel_in == PIX_FULL)
			spec_in = pgt_pkg::SP_FULL;
		else if (pixel_in == '0)
			spec_in = (gamma_q == '0) ? pgt_pkg::SP_FULL : pgt_pkg::SP_ZERO;
		else
			spec_in = pgt_pkg::SP_PASS;
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			lq_s1   <= pgt_pkg::LQ_ROM[pixel_in];
			spec_s1 <= spec_in;
		end
	end

	// Stage 2: exponent magnitude = |L| * gamma, rounded to Q16; above 16.0 forces zero
	logic [PROD_B-1:0]  n_prod;
	logic [NFULL_B-1:0] n_full;
	logic [NB-1:0]      n_s2;
	pgt_pkg::spec_t     spec_s2;

	assign n_prod = PROD_B'(lq_s1) * PROD_B'(gamma_q) + PROD_B'(2047);
	assign n_full = n_prod[PROD_B-1:12];

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			n_s2 <= n_full[NB-1:0];
			if (spec_s1 == pgt_pkg::SP_PASS && n_full > EXP_LIMIT)
				spec_s2 <= pgt_pkg::SP_ZERO;
			else
				spec_s2 <= spec_s1;
		end
	end

	// Stage 3: split into integer shift and positive fraction
	logic [15:0]    f_s2;
	logic [4:0]     i_s2;
	logic [15:0]    fr_s3;
	logic [4:0]     ni_s3;
	pgt_pkg::spec_t spec_s3;

	assign f_s2 = n_s2[15:0];
	assign i_s2 = n_s2[NB-1:16];

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			spec_s3 <= spec_s2;
			if (f_s2 == '0) begin
				ni_s3 <= i_s2;
				fr_s3 <= '0;
			end else begin
				ni_s3 <= i_s2 + 5'd1;
				fr_s3 <= (~f_s2) + 16'd1;
			end
		end
	end

	// Stages 4..19: one root multiply per fraction bit, MSB first
	logic [MB-1:0]  exp_m_s    [0:LAST_E];
	logic [15:0]    exp_fr_s   [0:LAST_E];
	logic [4:0]     exp_ni_s   [0:LAST_E];
	pgt_pkg::spec_t exp_spec_s [0:LAST_E];

	for (genvar j = 0; j < pgt_pkg::EXP_STEPS; j++) begin : g_exp
		logic [MB-1:0]     m_in;
		logic [15:0]       fr_in;
		logic [4:0]        ni_in;
		pgt_pkg::spec_t    spec_in_e;
		logic [2*MB-1:0]   prod;

		if (j == 0) begin : g_first
			assign m_in      = pgt_pkg::MANT_ONE;
			assign fr_in     = fr_s3;
			assign ni_in     = ni_s3;
			assign spec_in_e = spec_s3;
		end else begin : g_next
			assign m_in      = exp_m_s[j-1];
			assign fr_in     = exp_fr_s[j-1];
			assign ni_in     = exp_ni_s[j-1];
			assign spec_in_e = exp_spec_s[j-1];
		end

		assign prod = (2*MB)'(m_in) * (2*MB)'(pgt_pkg::EXP_ROOTS[j]);

		always_ff @(posedge clk) begin
			if (adv[EXP_BASE+j]) begin
				exp_m_s[j]    <= fr_in[15-j] ? prod[pgt_pkg::FB+MB-1:pgt_pkg::FB] : m_in;
				exp_fr_s[j]   <= fr_in;
				exp_ni_s[j]   <= ni_in;
				exp_spec_s[j] <= spec_in_e;
			end
		end
	end

	// Stage 20: round 2^E into Q16 by a shift of 14 + ni
	logic [4:0]     sh;
	logic [MB+1:0]  rnd_sum;
	logic [MB+1:0]  shifted;
	logic [16:0]    p_s20;
	pgt_pkg::spec_t spec_s20;

	assign sh      = 5'd14 + exp_ni_s[LAST_E];
	assign rnd_sum = (MB+2)'(exp_m_s[LAST_E]) + ((MB+2)'(1) << (sh - 5'd1));
	assign shifted = rnd_sum >> sh;

	always_ff @(posedge clk) begin
		if (adv[NUM_STG-2]) begin
			p_s20    <= shifted[16:0];
			spec_s20 <= exp_spec_s[LAST_E];
		end
	end

	// Stage 21: scale by M and apply the override
	logic [PB+16:0] scaled;
	logic [PB-1:0]  pix_s21;

	assign scaled = (PB+17)'(p_s20) * (PB+17)'(PIX_FULL);

	always_ff @(posedge clk) begin
		if (adv[NUM_STG-1]) begin
			case (spec_s20)
				pgt_pkg::SP_FULL: pix_s21 <= PIX_FULL;
				pgt_pkg::SP_ZERO: pix_s21 <= '0;
				default:          pix_s21 <= scaled[PB+15:16];
			endcase
		end
	end

	assign pixel_out = pix_s21;

endmodule
